[rtl/mfbp_pkg.sv]
// ----------------------------------------------------------------------------
// mfbp_pkg
// Shared types and constants of the microphone frame buffer pool.
// ----------------------------------------------------------------------------
package mfbp_pkg;

   localparam int FRAMES    = 4;
   localparam int FRAME_LEN = 1024;
   localparam int MICS      = 8;
   localparam int SAMPLE_W  = 24;
   localparam int SLOT_W    = 2;
   localparam int ROW_W     = 10;
   localparam int ID_W      = 32;
   localparam int TIME_W    = 64;
   localparam int MIC_W     = MICS * SAMPLE_W;
   localparam int ROW_BITS  = $clog2(FRAME_LEN);
   localparam int FRM_BITS  = $clog2(FRAMES);
   localparam int ADDR_W    = FRM_BITS + ROW_BITS;
   localparam int FILL_W    = ROW_BITS + 1;
   localparam int DEPTH     = FRAMES * FRAME_LEN;

   localparam int REQ_DATA_W = 272;
   localparam int RSP_DATA_W = 336;

   typedef enum logic [1:0] {
      SLOT_FREE, SLOT_WRITING, SLOT_READY, SLOT_READING
   } slot_state_type;

   typedef enum logic [1:0] {
      OP_PUSH, OP_ACQUIRE, OP_RELEASE, OP_READ
   } op_type;

   typedef enum logic [2:0] {
      STAT_STORED, STAT_COMPLETE, STAT_DROPPED, STAT_OVERFLOW,
      STAT_GRANTED, STAT_NONE_READY, STAT_RELEASED, STAT_READ
   } status_type;

   typedef enum logic [1:0] {
      BLK_NORMAL, BLK_DROP, BLK_DISCARD
   } blk_mode_type;

   typedef enum logic {
      BK_IDLE, BK_EXEC
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic                block_start;
      logic [TIME_W-1:0]   time_us;
      logic [MIC_W-1:0]    mics;
      logic [SLOT_W-1:0]   slot;
      logic [ROW_W-1:0]    row;
   } cmd_type;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [ID_W-1:0]     frame_number;
      logic [TIME_W-1:0]   frame_time_us;
      logic [ROW_W-1:0]    row;
      logic [MIC_W-1:0]    mics;
      logic [ID_W-1:0]     dropped_blocks;
   } result_type;

endpackage

[rtl/mic_frame_buffer_pool_top.sv]
// ----------------------------------------------------------------------------
// mic_frame_buffer_pool_top
// Pool of frame buffers for 8-microphone audio with producer and consumer ops.
// ----------------------------------------------------------------------------
// Each request transaction gives exactly one response transaction. Requests
// land in a two-deep command queue; the executor takes one command at a time
// (sample memory read, then execute and load the result register), and it
// takes no new command before it is through with the last one, even
// while responses are taken at once. The result register lets the next command
// be pulled in the cycle its predecessor's response is accepted. Samples sit
// in a single-port-write, single-read memory of FRAMES x FRAME_LEN rows of all
// eight mics; rows never written read back as undefined data. No clearing
// pass is needed after reset.
module mic_frame_buffer_pool_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // block_start[0], time_us[64:1], mics_0_1[112:65], mics_2_3[160:113],
   // mics_4_5[208:161], mics_6_7[256:209], slot_in[258:257], row_in[268:259]
   input  logic [271:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // slot_out[1:0], frame_number[33:2], frame_time_us[97:34], row_out[107:98],
   // out_mics_0_1[155:108], out_mics_2_3[203:156], out_mics_4_5[251:204],
   // out_mics_6_7[299:252], dropped_blocks[331:300]
   output logic [335:0] rsp_tdata,
   // status[2:0]
   output logic [2:0]   rsp_tuser
);

   logic                 cmd_valid, cmd_ready;
   mfbp_pkg::cmd_type    cmd;
   mfbp_pkg::result_type res;

   mfbp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   mfbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (res)
   );

   // pack result fields, lowest first
   assign rsp_tuser = res.status;
   assign rsp_tdata = {4'd0, res.dropped_blocks, res.mics, res.row,
                       res.frame_time_us, res.frame_number, res.slot};

endmodule

[rtl/mfbp_front.sv]
// ----------------------------------------------------------------------------
// mfbp_front
// Accepts request transactions, decodes the mode and queues the commands.
// ----------------------------------------------------------------------------
module mfbp_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [mfbp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                     req_tuser,
   output logic                           cmd_valid,
   input  logic                           cmd_ready,
   output mfbp_pkg::cmd_type              cmd
);

   mfbp_pkg::cmd_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   mfbp_pkg::cmd_type dec;
   logic              push, pop;

   always_comb begin
      dec.op          = mfbp_pkg::op_type'(req_tuser);
      dec.block_start = req_tdata[0];
      dec.time_us     = req_tdata[64:1];
      dec.mics        = req_tdata[256:65];
      dec.slot        = req_tdata[258:257];
      dec.row         = req_tdata[268:259];
   end

   assign req_tready = (count_ff != 2'd2);
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = q_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

[rtl/mfbp_back.sv]
// ----------------------------------------------------------------------------
// mfbp_back
// Executes queued commands against the slot table and the sample memory.
// ----------------------------------------------------------------------------
module mfbp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  mfbp_pkg::cmd_type    cmd,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mfbp_pkg::result_type rsp
);

   localparam int FW = mfbp_pkg::FILL_W;

   // sample memory, one row of all mics per entry
   logic [mfbp_pkg::MIC_W-1:0]  mem [mfbp_pkg::DEPTH];
   logic [mfbp_pkg::MIC_W-1:0]  mem_rdata_ff;
   logic                        mem_we;
   logic [mfbp_pkg::ADDR_W-1:0] mem_waddr;

   mfbp_pkg::back_state_type state_ff, state_in;
   mfbp_pkg::cmd_type        work_ff;

   mfbp_pkg::slot_state_type slot_state_ff [mfbp_pkg::FRAMES];
   mfbp_pkg::slot_state_type slot_state_in [mfbp_pkg::FRAMES];
   logic [mfbp_pkg::ID_W-1:0]   slot_id_ff   [mfbp_pkg::FRAMES];
   logic [mfbp_pkg::ID_W-1:0]   slot_id_in   [mfbp_pkg::FRAMES];
   logic [FW-1:0]               slot_fill_ff [mfbp_pkg::FRAMES];
   logic [FW-1:0]               slot_fill_in [mfbp_pkg::FRAMES];
   logic [mfbp_pkg::TIME_W-1:0] slot_time_ff [mfbp_pkg::FRAMES];
   logic [mfbp_pkg::TIME_W-1:0] slot_time_in [mfbp_pkg::FRAMES];

   logic [mfbp_pkg::SLOT_W-1:0] active_slot_ff, active_slot_in;
   logic                        active_valid_ff, active_valid_in;
   logic [mfbp_pkg::ID_W-1:0]   next_id_ff, next_id_in;
   logic [mfbp_pkg::ID_W-1:0]   drop_count_ff, drop_count_in;
   mfbp_pkg::blk_mode_type      blk_mode_ff, blk_mode_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   mfbp_pkg::result_type rsp_ff, res;

   logic                        free_found;
   logic [mfbp_pkg::SLOT_W-1:0] free_idx;
   logic                        best_found;
   logic [mfbp_pkg::SLOT_W-1:0] best_idx;
   logic                        pop;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign pop       = (state_ff == mfbp_pkg::BK_IDLE) && cmd_valid
                      && (!rsp_valid_ff || rsp_ready);
   assign cmd_ready = pop;

   // lowest free slot and oldest ready slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      best_found = 1'b0;
      best_idx   = '0;
      for (int s = 0; s < mfbp_pkg::FRAMES; s++) begin
         if (!free_found && slot_state_ff[s] == mfbp_pkg::SLOT_FREE) begin
            free_found = 1'b1;
            free_idx   = mfbp_pkg::SLOT_W'(s);
         end
         if (slot_state_ff[s] == mfbp_pkg::SLOT_READY
             && (!best_found || slot_id_ff[s] < slot_id_ff[best_idx])) begin
            best_found = 1'b1;
            best_idx   = mfbp_pkg::SLOT_W'(s);
         end
      end
   end

   always_comb begin
      logic [FW-1:0]               pos;
      logic [FW-1:0]               pos_nx;
      logic [mfbp_pkg::SLOT_W-1:0] a;
      logic                        do_claim;
      mfbp_pkg::blk_mode_type      bm;
      pos             = '0;
      pos_nx          = '0;
      a               = active_slot_ff;
      do_claim        = 1'b0;
      bm              = blk_mode_ff;
      state_in        = state_ff;
      slot_state_in   = slot_state_ff;
      slot_id_in      = slot_id_ff;
      slot_fill_in    = slot_fill_ff;
      slot_time_in    = slot_time_ff;
      active_slot_in  = active_slot_ff;
      active_valid_in = active_valid_ff;
      next_id_in      = next_id_ff;
      drop_count_in   = drop_count_ff;
      blk_mode_in     = blk_mode_ff;
      mem_we          = 1'b0;
      mem_waddr       = '0;
      res             = '0;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         mfbp_pkg::BK_IDLE: begin
            if (pop) state_in = mfbp_pkg::BK_EXEC;
         end
         mfbp_pkg::BK_EXEC: begin
            state_in     = mfbp_pkg::BK_IDLE;
            rsp_valid_in = 1'b1;
            unique case (work_ff.op)
               mfbp_pkg::OP_PUSH: begin
                  if (work_ff.block_start && !active_valid_ff) begin
                     do_claim      = 1'b1;
                     drop_count_in = drop_count_ff + 1'b1;
                     blk_mode_in   = mfbp_pkg::BLK_DROP;
                     res.status    = mfbp_pkg::STAT_DROPPED;
                  end else begin
                     if (work_ff.block_start) bm = mfbp_pkg::BLK_NORMAL;
                     blk_mode_in = bm;
                     if (bm == mfbp_pkg::BLK_DROP) begin
                        res.status = mfbp_pkg::STAT_DROPPED;
                     end else if (bm == mfbp_pkg::BLK_DISCARD || !active_valid_ff) begin
                        res.status = mfbp_pkg::STAT_OVERFLOW;
                     end else begin
                        pos       = slot_fill_ff[a];
                        pos_nx    = pos + 1'b1;
                        mem_we    = 1'b1;
                        mem_waddr = {a[mfbp_pkg::FRM_BITS-1:0],
                                     pos[mfbp_pkg::ROW_BITS-1:0]};
                        if (pos == '0) slot_time_in[a] = work_ff.time_us;
                        slot_fill_in[a]   = pos_nx;
                        res.slot          = a;
                        res.frame_number  = slot_id_ff[a];
                        res.frame_time_us = (pos == '0) ? work_ff.time_us
                                                        : slot_time_ff[a];
                        res.row           = pos[mfbp_pkg::ROW_W-1:0];
                        if (pos_nx >= FW'(mfbp_pkg::FRAME_LEN)) begin
                           slot_state_in[a] = mfbp_pkg::SLOT_READY;
                           do_claim         = 1'b1;
                           blk_mode_in      = mfbp_pkg::BLK_DISCARD;
                           res.status       = mfbp_pkg::STAT_COMPLETE;
                        end else begin
                           res.status = mfbp_pkg::STAT_STORED;
                        end
                     end
                  end
                  if (do_claim) begin
                     active_valid_in = free_found;
                     if (free_found) begin
                        slot_state_in[free_idx] = mfbp_pkg::SLOT_WRITING;
                        slot_fill_in[free_idx]  = '0;
                        slot_id_in[free_idx]    = next_id_ff;
                        next_id_in              = next_id_ff + 1'b1;
                        active_slot_in          = free_idx;
                     end
                  end
               end
               mfbp_pkg::OP_ACQUIRE: begin
                  if (best_found) begin
                     slot_state_in[best_idx] = mfbp_pkg::SLOT_READING;
                     res.status        = mfbp_pkg::STAT_GRANTED;
                     res.slot          = best_idx;
                     res.frame_number  = slot_id_ff[best_idx];
                     res.frame_time_us = slot_time_ff[best_idx];
                  end else begin
                     res.status = mfbp_pkg::STAT_NONE_READY;
                  end
               end
               mfbp_pkg::OP_RELEASE: begin
                  res.status = mfbp_pkg::STAT_RELEASED;
                  res.slot   = work_ff.slot;
                  if ({1'b0, work_ff.slot} < (mfbp_pkg::SLOT_W+1)'(mfbp_pkg::FRAMES)) begin
                     res.frame_number  = slot_id_ff[work_ff.slot];
                     res.frame_time_us = slot_time_ff[work_ff.slot];
                     if (slot_state_ff[work_ff.slot] != mfbp_pkg::SLOT_WRITING) begin
                        slot_state_in[work_ff.slot] = mfbp_pkg::SLOT_FREE;
                        slot_fill_in[work_ff.slot]  = '0;
                     end
                  end
               end
               mfbp_pkg::OP_READ: begin
                  res.status = mfbp_pkg::STAT_READ;
                  res.slot   = work_ff.slot;
                  res.row    = work_ff.row;
                  if ({1'b0, work_ff.slot} < (mfbp_pkg::SLOT_W+1)'(mfbp_pkg::FRAMES)) begin
                     res.frame_number  = slot_id_ff[work_ff.slot];
                     res.frame_time_us = slot_time_ff[work_ff.slot];
                     if ({1'b0, work_ff.row} < (mfbp_pkg::ROW_W+1)'(mfbp_pkg::FRAME_LEN))
                        res.mics = mem_rdata_ff;
                  end
               end
               default: ;
            endcase
            res.dropped_blocks = drop_count_in;
         end
         default: state_in = mfbp_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= mfbp_pkg::BK_IDLE;
         rsp_valid_ff    <= 1'b0;
         active_slot_ff  <= '0;
         active_valid_ff <= 1'b1;
         next_id_ff      <= mfbp_pkg::ID_W'(1);
         drop_count_ff   <= '0;
         blk_mode_ff     <= mfbp_pkg::BLK_NORMAL;
         for (int s = 0; s < mfbp_pkg::FRAMES; s++) begin
            slot_state_ff[s] <= (s == 0) ? mfbp_pkg::SLOT_WRITING : mfbp_pkg::SLOT_FREE;
            slot_id_ff[s]    <= '0;
            slot_fill_ff[s]  <= '0;
            slot_time_ff[s]  <= '0;
         end
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         active_slot_ff  <= active_slot_in;
         active_valid_ff <= active_valid_in;
         next_id_ff      <= next_id_in;
         drop_count_ff   <= drop_count_in;
         blk_mode_ff     <= blk_mode_in;
         slot_state_ff   <= slot_state_in;
         slot_id_ff      <= slot_id_in;
         slot_fill_ff    <= slot_fill_in;
         slot_time_ff    <= slot_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) work_ff <= cmd;
      if (state_ff == mfbp_pkg::BK_EXEC) rsp_ff <= res;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= work_ff.mics;
      if (pop) mem_rdata_ff <= mem[{cmd.slot[mfbp_pkg::FRM_BITS-1:0],
                                    cmd.row[mfbp_pkg::ROW_BITS-1:0]}];
   end

`ifndef NO_ASSERTIONS
   a_exec_out_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == mfbp_pkg::BK_EXEC |-> !rsp_valid_ff)
      else $error("result register busy on execute");
   a_active_writing: assert property (@(posedge clock) disable iff (reset)
      active_valid_ff |-> slot_state_ff[active_slot_ff] == mfbp_pkg::SLOT_WRITING)
      else $error("active slot not in writing state");
   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == mfbp_pkg::BK_EXEC |=> rsp_valid_ff)
      else $error("executed command gave no result");
`endif

endmodule
